// File: rtl/lap3_pkg.sv
// Shared types, constants and helpers of the 3x3 Laplacian stream filter.
package lap3_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Smallest frame dimension the window supports
  localparam int MIN_DIM = 3;

  // Payload widths
  localparam int PIX_W = 8;
  localparam int POS_W = 10;

  // Classification of the pixel at the current raster position
  typedef struct packed {
    logic border;    // first/last row or column: passed through
    logic interior;  // window holds a full neighbourhood for (r-1,c-1)
  } pos_flags_t;

  // One result on the output channel
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             last;
  } result_t;

  // Clamp a programmed dimension into MIN_DIM..hi
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned       hi);
    int unsigned val;
    val = int'(v);
    if (val < MIN_DIM) begin
      return MIN_DIM;
    end
    if (val > hi) begin
      return hi;
    end
    return val;
  endfunction

endpackage

// File: rtl/laplacian_3x3_stream_filter.sv
// Top level of the streaming 3x3 four-neighbour Laplacian filter.
//
// Usage: grayscale pixels arrive in raster order on the input channel
// (in_valid_i / in_stall_o / pixel_in_i). Each pixel gives zero, one or two
// results on the output channel (out_valid_o / out_stall_i), each tagged with
// its row and column. A border pixel is passed straight through; the filtered
// value for interior pixel (r-1,c-1) leaves with pixel (r,c), before that
// pixel's own border result when it has one. last_of_run_o marks the final
// result caused by a pixel.
// A result passes the working stage into the output register; the edge accepting its
// pixel also reads the line store. Throughput: one pixel per cycle while the receiver
// does not stall and no pixel has two results; such a pixel holds the working stage
// until both leave, as the output register takes one result per cycle. Frame width
// and height are written through the configuration port; the user must write them
// only while the block is idle, which the block does not enforce. Reset clears the
// raster position and window, sets 640x480, and empties the pipeline; line store
// contents are not cleared. While the receiver stalls, the held result stays put and
// the input stalls once the working stage also holds a pixel with a result.
module laplacian_3x3_stream_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lap3_pkg::CFG_W-1:0]       cfg_wdata_i,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lap3_pkg::PIX_W-1:0]       pixel_in_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lap3_pkg::POS_W-1:0]       out_row_o,
  output logic [lap3_pkg::POS_W-1:0]       out_col_o,
  output logic [lap3_pkg::PIX_W-1:0]       out_value_o,
  output logic                             last_of_run_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = ($clog2(MAX_WIDTH + 1) > lap3_pkg::CFG_W) ?
                      $clog2(MAX_WIDTH + 1) : lap3_pkg::CFG_W;
  localparam int YW = ($clog2(MAX_HEIGHT + 1) > lap3_pkg::CFG_W) ?
                      $clog2(MAX_HEIGHT + 1) : lap3_pkg::CFG_W;

  logic                        in_accept;
  logic [YW-1:0]               pos_row;
  logic [XW-1:0]               pos_col;
  lap3_pkg::pos_flags_t        pos_flags;

  // Working stage
  logic                        s1_valid_q;
  logic [lap3_pkg::PIX_W-1:0]  s1_pix_q;
  logic [YW-1:0]               s1_row_q;
  logic [XW-1:0]               s1_col_q;
  lap3_pkg::pos_flags_t        s1_flags_q;
  logic                        phase_q;

  logic [2*lap3_pkg::PIX_W-1:0] line_rd;
  logic [lap3_pkg::PIX_W-1:0]   lap_value;
  logic [YW-1:0]                row_up;
  logic [XW-1:0]                col_left;

  logic                        out_free, need_two, no_result, emit, s1_done;
  lap3_pkg::result_t           res_d;
  lap3_pkg::result_t           out_q;
  logic                        out_valid_q;

  assign in_accept = in_valid_i && !in_stall_o;

  // Raster position and geometry
  lap3_raster #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .XW        (XW),
    .YW        (YW)
  ) u_raster (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .advance_i  (in_accept),
    .row_o      (pos_row),
    .col_o      (pos_col),
    .flags_o    (pos_flags)
  );

  // Line store: read at accept, write back when the request retires
  lap3_line_buf #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (in_accept),
    .rd_addr_i(pos_col[AW-1:0]),
    .rd_data_o(line_rd),
    .wr_en_i  (s1_done),
    .wr_addr_i(s1_col_q[AW-1:0]),
    .wr_data_i({line_rd[lap3_pkg::PIX_W-1:0], s1_pix_q})
  );

  // Window and Laplacian
  lap3_kernel u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_done),
    .col_two_i(line_rd[2*lap3_pkg::PIX_W-1:lap3_pkg::PIX_W]),
    .col_one_i(line_rd[lap3_pkg::PIX_W-1:0]),
    .col_pix_i(s1_pix_q),
    .value_o  (lap_value)
  );

  // Working stage control
  assign out_free  = !out_valid_q || !out_stall_i;
  assign need_two  = s1_flags_q.interior && s1_flags_q.border;
  assign no_result = !s1_flags_q.interior && !s1_flags_q.border;
  assign emit      = s1_valid_q && !no_result && out_free;
  assign s1_done   = s1_valid_q && (no_result || (out_free && (!need_two || phase_q)));
  assign in_stall_o = s1_valid_q && !s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_done);
      if (s1_done) begin
        phase_q <= 1'b0;
      end else if (emit && need_two) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= pixel_in_i;
      s1_row_q   <= pos_row;
      s1_col_q   <= pos_col;
      s1_flags_q <= pos_flags;
    end
  end

  // Result select: interior result first, border pass-through second
  assign row_up   = s1_row_q - YW'(1);
  assign col_left = s1_col_q - XW'(1);

  always_comb begin
    if (s1_flags_q.interior && !phase_q) begin
      res_d.row   = row_up[lap3_pkg::POS_W-1:0];
      res_d.col   = col_left[lap3_pkg::POS_W-1:0];
      res_d.value = lap_value;
      res_d.last  = !s1_flags_q.border;
    end else begin
      res_d.row   = s1_row_q[lap3_pkg::POS_W-1:0];
      res_d.col   = s1_col_q[lap3_pkg::POS_W-1:0];
      res_d.value = s1_pix_q;
      res_d.last  = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_q.row;
  assign out_col_o     = out_q.col;
  assign out_value_o   = out_q.value;
  assign last_of_run_o = out_q.last;

`ifndef ASSERT_OFF
  // second phase only exists for a held pixel with two results
  a_phase_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (s1_valid_q && need_two))
    else $error("second phase without a two-result pixel");

  // interior result of a two-result pixel goes out marked not last
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && need_two && !phase_q) |=> (out_valid_q && !out_q.last))
    else $error("first of two results marked last");

  // a non-final result waiting means its border partner is still held
  a_partner_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> (s1_valid_q && phase_q))
    else $error("non-final result without pending partner");

  // input only stalls behind an occupied working stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && !no_result && (!out_free || (need_two && !phase_q))))
    else $error("input stalled without cause");
`endif

endmodule

// File: rtl/lap3_line_buf.sv
// Two-row line store: one entry per column holding rows r-2 and r-1.
module lap3_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [2*lap3_pkg::PIX_W-1:0]  rd_data_o,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [2*lap3_pkg::PIX_W-1:0]  wr_data_i
);

  logic [2*lap3_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [2*lap3_pkg::PIX_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/lap3_raster.sv
// Frame geometry registers and raster position tracking.
module lap3_raster #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int XW         = 11,
  parameter int YW         = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lap3_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             advance_i,
  output logic [YW-1:0]                    row_o,
  output logic [XW-1:0]                    col_o,
  output lap3_pkg::pos_flags_t             flags_o
);

  localparam logic [XW-1:0] RST_WIDTH =
    XW'(lap3_pkg::clamp_dim(lap3_pkg::FRAME_WIDTH_RST, MAX_WIDTH));
  localparam logic [YW-1:0] RST_HEIGHT =
    YW'(lap3_pkg::clamp_dim(lap3_pkg::FRAME_HEIGHT_RST, MAX_HEIGHT));

  logic [XW-1:0] width_q, col_q, col_d, cur_col, col_inc;
  logic [YW-1:0] height_q, row_q, row_d, cur_row, row_pre, row_inc;

  // Geometry registers, stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lap3_pkg::REG_FRAME_WIDTH: begin
          width_q <= XW'(lap3_pkg::clamp_dim(cfg_wdata_i, MAX_WIDTH));
        end
        lap3_pkg::REG_FRAME_HEIGHT: begin
          height_q <= YW'(lap3_pkg::clamp_dim(cfg_wdata_i, MAX_HEIGHT));
        end
        default: ;
      endcase
    end
  end

  // Position of the arriving pixel; re-fit to the geometry in case it shrank
  always_comb begin
    if (col_q >= width_q) begin
      cur_col = '0;
      row_pre = row_q + YW'(1);
    end else begin
      cur_col = col_q;
      row_pre = row_q;
    end
    cur_row = (row_pre >= height_q) ? '0 : row_pre;

    // Position after this pixel, wrapping at row and frame end
    col_inc = cur_col + XW'(1);
    row_inc = cur_row + YW'(1);
    if (col_inc >= width_q) begin
      col_d = '0;
      row_d = (row_inc >= height_q) ? '0 : row_inc;
    end else begin
      col_d = col_inc;
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (advance_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o = cur_row;
  assign col_o = cur_col;

  assign flags_o.border   = (cur_row == '0) || (cur_row == height_q - YW'(1)) ||
                            (cur_col == '0) || (cur_col == width_q - XW'(1));
  assign flags_o.interior = (cur_row >= YW'(2)) && (cur_col >= XW'(2));

endmodule

// File: rtl/lap3_kernel.sv
// Sliding window registers and the four-neighbour Laplacian with clamp.
module lap3_kernel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [lap3_pkg::PIX_W-1:0]  col_two_i,  // row r-2 at column c
  input  logic [lap3_pkg::PIX_W-1:0]  col_one_i,  // row r-1 at column c
  input  logic [lap3_pkg::PIX_W-1:0]  col_pix_i,  // row r at column c
  output logic [lap3_pkg::PIX_W-1:0]  value_o
);

  localparam int SUM_W = lap3_pkg::PIX_W + 2;

  // Only the taps the cross-shaped kernel ever reads are kept
  logic [lap3_pkg::PIX_W-1:0] north_q, south_q, mid_w_q, mid_c_q;
  logic [SUM_W-1:0]           pos_sum, neg_sum, diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      north_q <= '0;
      south_q <= '0;
      mid_w_q <= '0;
      mid_c_q <= '0;
    end else if (shift_i) begin
      north_q <= col_two_i;
      mid_w_q <= mid_c_q;
      mid_c_q <= col_one_i;
      south_q <= col_pix_i;
    end
  end

  // Before the shift, the centre is mid_c_q and the east tap is the new column
  always_comb begin
    pos_sum = SUM_W'(north_q) + SUM_W'(south_q) + SUM_W'(mid_w_q) + SUM_W'(col_one_i);
    neg_sum = {mid_c_q, 2'b00};
    diff    = pos_sum - neg_sum;
    if (neg_sum >= pos_sum) begin
      value_o = '0;
    end else if (diff > SUM_W'(255)) begin
      value_o = '1;
    end else begin
      value_o = diff[lap3_pkg::PIX_W-1:0];
    end
  end

endmodule
